// ----- rtl/core/psc_pkg.sv -----
package psc_pkg;

  // Defaults of the top-level parameters.
  localparam int FRAC_BITS_DEFAULT = 24;
  localparam int DUTY_MAX_DEFAULT  = 100;

  // Field widths.
  localparam int GAIN_W     = 24;
  localparam int HOLD_W     = 10;
  localparam int STEP_W     = 8;
  localparam int SETPOINT_W = 12;
  localparam int PERIOD_W   = 8;
  localparam int SPEED_W    = 13;
  localparam int DUTY_W     = 7;
  localparam int DRIVE_W    = 8;

  // Speed error and gain products.
  localparam int ERR_W  = 14;
  localparam int PROD_W = ERR_W + GAIN_W + 1;

  // Saturation value of the both-buttons hold counter.
  localparam logic [HOLD_W-1:0] HOLD_SAT = '1;

  // Configuration port.
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // Register reset values.
  localparam logic [GAIN_W-1:0]     KP_GAIN_RESET        = 24'd3187671;
  localparam logic [GAIN_W-1:0]     KI_GAIN_RESET        = 24'd5033;
  localparam logic [HOLD_W-1:0]     HOLD_TICKS_RESET     = 10'd200;
  localparam logic [STEP_W-1:0]     SETPOINT_STEP_RESET  = 8'd50;
  localparam logic [SETPOINT_W-1:0] SETPOINT_MAX_RESET   = 12'd1950;
  localparam logic [PERIOD_W-1:0]   DISPLAY_PERIOD_RESET = 8'd10;

  // Register indexes, taken from paddr[4:2].
  typedef enum logic [2:0] {
    REG_KP_GAIN,
    REG_KI_GAIN,
    REG_HOLD_TICKS,
    REG_SETPOINT_STEP,
    REG_SETPOINT_MAX,
    REG_DISPLAY_PERIOD
  } psc_reg_t;

  // Configuration register set.
  typedef struct packed {
    logic [GAIN_W-1:0]     kp_gain;
    logic [GAIN_W-1:0]     ki_gain;
    logic [HOLD_W-1:0]     hold_ticks;
    logic [STEP_W-1:0]     setpoint_step;
    logic [SETPOINT_W-1:0] setpoint_max;
    logic [PERIOD_W-1:0]   display_period;
  } psc_cfg_t;

  // Result of the button logic for one tick, handed to the PI stages.
  typedef struct packed {
    logic                    closed_loop;
    logic [DUTY_W-1:0]       duty_percent;
    logic [SETPOINT_W-1:0]   speed_setpoint;
    logic                    display_strobe;
    logic signed [ERR_W-1:0] err;
  } psc_tick_t;

endpackage

// ----- rtl/core/psc_buttons.sv -----
module psc_buttons #(
  parameter int DUTY_MAX = psc_pkg::DUTY_MAX_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 load,
  input  logic                                 up_pressed,
  input  logic                                 down_pressed,
  input  logic signed [psc_pkg::SPEED_W-1:0]   measured_speed,
  input  psc_pkg::psc_cfg_t                    cfg,
  output psc_pkg::psc_tick_t                   tick
);

  localparam logic signed [8:0] DUTY_LIM = 9'(DUTY_MAX);

  // Button and display state.
  logic                              up_latch, up_latch_next;
  logic                              down_latch, down_latch_next;
  logic                              mode_bit, mode_bit_next;
  logic [psc_pkg::DUTY_W-1:0]        duty_value, duty_value_next;
  logic [psc_pkg::SETPOINT_W-1:0]    target_speed, target_speed_next;
  logic [psc_pkg::HOLD_W-1:0]        up_hold_count, up_hold_count_next;
  logic [psc_pkg::HOLD_W-1:0]        down_hold_count, down_hold_count_next;
  logic [psc_pkg::HOLD_W-1:0]        both_hold_count, both_hold_count_next;
  logic [psc_pkg::PERIOD_W-1:0]      strobe_count, strobe_count_next;
  logic                              strobe;
  logic signed [psc_pkg::ERR_W-1:0]  err;

  // Working values of one tick.
  logic                              up_release, down_release, toggle;
  logic signed [8:0]                 duty_work;
  logic signed [13:0]                target_work;
  logic [psc_pkg::HOLD_W:0]          up_run, down_run;
  logic [psc_pkg::PERIOD_W:0]        strobe_run;

  // Release detection, mode toggle, auto-step, clamping, display strobe and speed error.
  always_comb begin
    up_release      = !up_pressed && up_latch;
    down_release    = !down_pressed && down_latch;
    up_latch_next   = up_pressed;
    down_latch_next = down_pressed;

    duty_work   = $signed({2'b00, duty_value});
    target_work = $signed({2'b00, target_speed});
    if (up_release) begin
      if (mode_bit) begin
        target_work = target_work + $signed({6'd0, cfg.setpoint_step});
      end else begin
        duty_work = duty_work + 9'sd1;
      end
    end
    if (down_release) begin
      if (mode_bit) begin
        target_work = target_work - $signed({6'd0, cfg.setpoint_step});
      end else begin
        duty_work = duty_work - 9'sd1;
      end
    end

    // Both buttons held: count up to saturation, toggle when the count hits the hold length.
    toggle = 1'b0;
    if (up_pressed && down_pressed) begin
      if (both_hold_count < psc_pkg::HOLD_SAT) begin
        both_hold_count_next = both_hold_count + 1'b1;
        toggle = (both_hold_count_next == cfg.hold_ticks);
      end else begin
        both_hold_count_next = both_hold_count;
      end
    end else begin
      both_hold_count_next = '0;
    end
    mode_bit_next = mode_bit ^ toggle;
    if (toggle) begin
      duty_work   = '0;
      target_work = '0;
    end

    // Auto-step while a button is held.
    up_run   = up_pressed ? {1'b0, up_hold_count} + 1'b1 : '0;
    down_run = down_pressed ? {1'b0, down_hold_count} + 1'b1 : '0;
    if (up_run >= {1'b0, cfg.hold_ticks}) begin
      duty_work = duty_work + 9'sd1;
      up_run    = '0;
    end
    if (down_run >= {1'b0, cfg.hold_ticks}) begin
      duty_work = duty_work - 9'sd1;
      down_run  = '0;
    end
    up_hold_count_next   = up_run[psc_pkg::HOLD_W-1:0];
    down_hold_count_next = down_run[psc_pkg::HOLD_W-1:0];

    // Clamp the duty and the setpoint.
    if (duty_work < 9'sd0) begin
      duty_work = '0;
    end else if (duty_work > DUTY_LIM) begin
      duty_work = DUTY_LIM;
    end
    duty_value_next = duty_work[psc_pkg::DUTY_W-1:0];
    if (target_work < 14'sd0) begin
      target_work = '0;
    end else if (target_work > $signed({2'b00, cfg.setpoint_max})) begin
      target_work = $signed({2'b00, cfg.setpoint_max});
    end
    target_speed_next = target_work[psc_pkg::SETPOINT_W-1:0];

    // Display strobe.
    strobe     = 1'b0;
    strobe_run = {1'b0, strobe_count} + 1'b1;
    if (strobe_run >= {1'b0, cfg.display_period}) begin
      strobe     = 1'b1;
      strobe_run = '0;
    end
    strobe_count_next = strobe_run[psc_pkg::PERIOD_W-1:0];

    // Speed error against the new setpoint.
    err = $signed({2'b00, target_speed_next}) - $signed({measured_speed[psc_pkg::SPEED_W-1],
                                                         measured_speed});
  end

  // State registers advance once per tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      up_latch        <= 1'b0;
      down_latch      <= 1'b0;
      mode_bit        <= 1'b0;
      duty_value      <= '0;
      target_speed    <= '0;
      up_hold_count   <= '0;
      down_hold_count <= '0;
      both_hold_count <= '0;
      strobe_count    <= '0;
    end else if (load) begin
      up_latch        <= up_latch_next;
      down_latch      <= down_latch_next;
      mode_bit        <= mode_bit_next;
      duty_value      <= duty_value_next;
      target_speed    <= target_speed_next;
      up_hold_count   <= up_hold_count_next;
      down_hold_count <= down_hold_count_next;
      both_hold_count <= both_hold_count_next;
      strobe_count    <= strobe_count_next;
    end
  end

  // Tick result register.
  always_ff @(posedge clk) begin
    if (load) begin
      tick.closed_loop    <= mode_bit_next;
      tick.duty_percent   <= duty_value_next;
      tick.speed_setpoint <= target_speed_next;
      tick.display_strobe <= strobe;
      tick.err            <= err;
    end
  end

  // The stored duty never leaves its range.
  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    load |=> (duty_value <= 7'(DUTY_MAX)))
    else $error("duty above full scale");

  // The strobe counter is always below the period, or zero.
  a_strobe_count: assert property (@(posedge clk) disable iff (rst)
    load |=> (strobe_count < cfg.display_period) || (strobe_count == '0))
    else $error("strobe counter not wrapped");

endmodule

// ----- rtl/core/psc_pi.sv -----
module psc_pi #(
  parameter int FRAC_BITS = psc_pkg::FRAC_BITS_DEFAULT,
  parameter int DUTY_MAX  = psc_pkg::DUTY_MAX_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               load_prod,
  input  logic                               load_out,
  input  psc_pkg::psc_tick_t                 tick,
  input  logic [psc_pkg::GAIN_W-1:0]         kp_gain,
  input  logic [psc_pkg::GAIN_W-1:0]         ki_gain,
  output logic [psc_pkg::DRIVE_W-1:0]        drive_level,
  output logic                               closed_loop,
  output logic [psc_pkg::DUTY_W-1:0]         duty_percent,
  output logic [psc_pkg::SETPOINT_W-1:0]     speed_setpoint,
  output logic                               display_strobe
);

  localparam int PROD_W  = psc_pkg::PROD_W;
  localparam int INT_W   = FRAC_BITS + 12;
  localparam int WIDE_W  = (PROD_W > INT_W) ? PROD_W : INT_W;
  localparam int ACC_W   = WIDE_W + 2;
  localparam int TABLE_N = 2 ** psc_pkg::DUTY_W;
  localparam logic signed [ACC_W-1:0] LIM      = $signed(ACC_W'(64'd1024 << FRAC_BITS));
  localparam logic signed [ACC_W-1:0] FULL     = ACC_W'(255);
  localparam logic signed [ACC_W-1:0] ZERO     = '0;
  localparam logic [psc_pkg::DRIVE_W-1:0] DRIVE_FULL = '1;

  // Open-loop drive table: duty * 255 / full scale.
  logic [psc_pkg::DRIVE_W-1:0] drive_table [TABLE_N];
  for (genvar g = 0; g < TABLE_N; g++) begin : g_drive
    localparam int Raw = (g * 255) / DUTY_MAX;
    assign drive_table[g] = (Raw > 255) ? DRIVE_FULL : psc_pkg::DRIVE_W'(Raw);
  end

  // Product stage.
  logic signed [PROD_W-1:0] err_ext, kp_ext, ki_ext;
  logic signed [PROD_W-1:0] p_prod, i_prod;
  psc_pkg::psc_tick_t       tick_prod;

  assign err_ext = {{(PROD_W - psc_pkg::ERR_W){tick.err[psc_pkg::ERR_W-1]}}, tick.err};
  assign kp_ext  = $signed({{(PROD_W - psc_pkg::GAIN_W){1'b0}}, kp_gain});
  assign ki_ext  = $signed({{(PROD_W - psc_pkg::GAIN_W){1'b0}}, ki_gain});

  always_ff @(posedge clk) begin
    if (load_prod) begin
      p_prod    <= err_ext * kp_ext;
      i_prod    <= err_ext * ki_ext;
      tick_prod <= tick;
    end
  end

  // Integrator state.
  logic signed [INT_W-1:0]     integral;
  logic                        below_max;
  logic signed [ACC_W-1:0]     int_ext, int_add, int_sat, int_use, sum, whole;
  logic [psc_pkg::DRIVE_W-1:0] pi_drive, drive;

  // Conditional integration, saturation and drive selection.
  always_comb begin
    int_ext = {{(ACC_W - INT_W){integral[INT_W-1]}}, integral};
    int_add = int_ext + {{(ACC_W - PROD_W){i_prod[PROD_W-1]}}, i_prod};
    if (int_add > LIM) begin
      int_sat = LIM;
    end else if (int_add < -LIM) begin
      int_sat = -LIM;
    end else begin
      int_sat = int_add;
    end
    int_use = below_max ? int_sat : int_ext;
    sum     = {{(ACC_W - PROD_W){p_prod[PROD_W-1]}}, p_prod} + int_use;
    whole   = sum >>> FRAC_BITS;
    if (sum <= ZERO) begin
      pi_drive = '0;
    end else if (whole >= FULL) begin
      pi_drive = DRIVE_FULL;
    end else begin
      pi_drive = whole[psc_pkg::DRIVE_W-1:0];
    end
    drive = tick_prod.closed_loop ? pi_drive : drive_table[tick_prod.duty_percent];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integral  <= '0;
      below_max <= 1'b1;
    end else if (load_out && tick_prod.closed_loop) begin
      integral  <= int_use[INT_W-1:0];
      below_max <= (pi_drive != DRIVE_FULL);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (load_out) begin
      drive_level    <= drive;
      closed_loop    <= tick_prod.closed_loop;
      duty_percent   <= tick_prod.duty_percent;
      speed_setpoint <= tick_prod.speed_setpoint;
      display_strobe <= tick_prod.display_strobe;
    end
  end

  // Integration is allowed on the next tick only if this drive stayed below full.
  a_below_max: assert property (@(posedge clk) disable iff (rst)
    load_out && tick_prod.closed_loop |=> below_max == (drive_level != DRIVE_FULL))
    else $error("below_max out of step with drive");

  // The integral stays inside its saturation bounds.
  a_int_bound: assert property (@(posedge clk) disable iff (rst)
    load_out |=> ($signed({{(ACC_W - INT_W){integral[INT_W-1]}}, integral}) <= LIM) &&
                 ($signed({{(ACC_W - INT_W){integral[INT_W-1]}}, integral}) >= -LIM))
    else $error("integral beyond saturation");

endmodule

// ----- rtl/core/pi_speed_controller_with_buttons.sv -----
// Button-operated motor speed controller, one item per millisecond tick.
// Input channel (in_valid / in_stall): button levels and measured speed of one tick.
// Output channel (out_valid / out_stall): drive byte, mode, duty, setpoint and
// display strobe for that tick. A transfer happens when valid is high and stall low.
// Configuration goes through the APB port: kp_gain at 0x00, ki_gain 0x04,
// hold_ticks 0x08, setpoint_step 0x0C, setpoint_max 0x10, display_period 0x14.
// Write registers only while the pipeline is empty.
// Path: an item passes the input register, the button-logic register, the
// gain-product register and the output register, where the PI update is done.
// Throughput: one item per cycle while out_stall stays low. The button state
// closes its loop inside the button stage and the integrator closes its loop
// inside the output stage.
// Reset clears the pipeline, the button and integrator state and loads the
// default register values. When the receiver stalls, the result is held and the
// four pipeline registers fill; in_stall rises once all of them hold items.
module pi_speed_controller_with_buttons #(
  parameter int FRAC_BITS = psc_pkg::FRAC_BITS_DEFAULT,
  parameter int DUTY_MAX  = psc_pkg::DUTY_MAX_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  // Input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              up_pressed,
  input  logic                              down_pressed,
  input  logic signed [psc_pkg::SPEED_W-1:0] measured_speed,
  // Output channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [psc_pkg::DRIVE_W-1:0]       drive_level,
  output logic                              closed_loop,
  output logic [psc_pkg::DUTY_W-1:0]        duty_percent,
  output logic [psc_pkg::SETPOINT_W-1:0]    speed_setpoint,
  output logic                              display_strobe,
  // Configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [psc_pkg::ADDR_W-1:0]        paddr,
  input  logic [psc_pkg::DATA_W-1:0]        pwdata,
  output logic [psc_pkg::DATA_W-1:0]        prdata,
  output logic                              pready
);

  psc_pkg::psc_cfg_t cfg;
  psc_pkg::psc_reg_t reg_index;
  logic              cfg_write;

  assign pready    = 1'b1;
  assign reg_index = psc_pkg::psc_reg_t'(paddr[psc_pkg::ADDR_W-1:2]);
  assign cfg_write = psel && penable && pwrite;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kp_gain        <= psc_pkg::KP_GAIN_RESET;
      cfg.ki_gain        <= psc_pkg::KI_GAIN_RESET;
      cfg.hold_ticks     <= psc_pkg::HOLD_TICKS_RESET;
      cfg.setpoint_step  <= psc_pkg::SETPOINT_STEP_RESET;
      cfg.setpoint_max   <= psc_pkg::SETPOINT_MAX_RESET;
      cfg.display_period <= psc_pkg::DISPLAY_PERIOD_RESET;
    end else if (cfg_write) begin
      case (reg_index)
        psc_pkg::REG_KP_GAIN:        cfg.kp_gain        <= pwdata[psc_pkg::GAIN_W-1:0];
        psc_pkg::REG_KI_GAIN:        cfg.ki_gain        <= pwdata[psc_pkg::GAIN_W-1:0];
        psc_pkg::REG_HOLD_TICKS:     cfg.hold_ticks     <= pwdata[psc_pkg::HOLD_W-1:0];
        psc_pkg::REG_SETPOINT_STEP:  cfg.setpoint_step  <= pwdata[psc_pkg::STEP_W-1:0];
        psc_pkg::REG_SETPOINT_MAX:   cfg.setpoint_max   <= pwdata[psc_pkg::SETPOINT_W-1:0];
        psc_pkg::REG_DISPLAY_PERIOD: cfg.display_period <= pwdata[psc_pkg::PERIOD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (reg_index)
      psc_pkg::REG_KP_GAIN:        prdata = psc_pkg::DATA_W'(cfg.kp_gain);
      psc_pkg::REG_KI_GAIN:        prdata = psc_pkg::DATA_W'(cfg.ki_gain);
      psc_pkg::REG_HOLD_TICKS:     prdata = psc_pkg::DATA_W'(cfg.hold_ticks);
      psc_pkg::REG_SETPOINT_STEP:  prdata = psc_pkg::DATA_W'(cfg.setpoint_step);
      psc_pkg::REG_SETPOINT_MAX:   prdata = psc_pkg::DATA_W'(cfg.setpoint_max);
      psc_pkg::REG_DISPLAY_PERIOD: prdata = psc_pkg::DATA_W'(cfg.display_period);
      default:                     prdata = '0;
    endcase
  end

  // Pipeline flow control: a stage loads when the one ahead is empty or moving on.
  logic v0, v1, v2, v3;
  logic load0, load1, load2, load3;
  logic free0, free1, free2, free3;

  assign free3    = !v3 || !out_stall;
  assign load3    = v2 && free3;
  assign free2    = !v2 || load3;
  assign load2    = v1 && free2;
  assign free1    = !v1 || load2;
  assign load1    = v0 && free1;
  assign free0    = !v0 || load1;
  assign load0    = in_valid && free0;
  assign in_stall = !free0;
  assign out_valid = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v0 <= load0 || (v0 && !load1);
      v1 <= load1 || (v1 && !load2);
      v2 <= load2 || (v2 && !load3);
      v3 <= load3 || (v3 && out_stall);
    end
  end

  // Input register.
  logic                               up_in, down_in;
  logic signed [psc_pkg::SPEED_W-1:0] speed_in;

  always_ff @(posedge clk) begin
    if (load0) begin
      up_in    <= up_pressed;
      down_in  <= down_pressed;
      speed_in <= measured_speed;
    end
  end

  psc_pkg::psc_tick_t tick;

  psc_buttons #(
    .DUTY_MAX(DUTY_MAX)
  ) u_buttons (
    .clk           (clk),
    .rst           (rst),
    .load          (load1),
    .up_pressed    (up_in),
    .down_pressed  (down_in),
    .measured_speed(speed_in),
    .cfg           (cfg),
    .tick          (tick)
  );

  psc_pi #(
    .FRAC_BITS(FRAC_BITS),
    .DUTY_MAX (DUTY_MAX)
  ) u_pi (
    .clk           (clk),
    .rst           (rst),
    .load_prod     (load2),
    .load_out      (load3),
    .tick          (tick),
    .kp_gain       (cfg.kp_gain),
    .ki_gain       (cfg.ki_gain),
    .drive_level   (drive_level),
    .closed_loop   (closed_loop),
    .duty_percent  (duty_percent),
    .speed_setpoint(speed_setpoint),
    .display_strobe(display_strobe)
  );

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

  localparam int FRAC    = psc_pkg::FRAC_BITS_DEFAULT;
  localparam int DUTY_FS = psc_pkg::DUTY_MAX_DEFAULT;
  // Cycles without any transfer before the run is declared hung.
  localparam int STALL_LIMIT = 2000;

  // One result of the block, as seen on the output channel.
  typedef struct packed {
    logic [psc_pkg::DRIVE_W-1:0]    drive;
    logic                           mode;
    logic [psc_pkg::DUTY_W-1:0]     duty;
    logic [psc_pkg::SETPOINT_W-1:0] setpoint;
    logic                           strobe;
  } tick_out_t;

  // Tracks the controller state tick by tick and checks every result in order.
  class tick_scoreboard_t;
    longint kp, ki;
    int hold, sp_step, sp_max, period;
    bit up_latch, down_latch, mode, below_max;
    int duty, target, up_hold, down_hold, both_hold, strobe_cnt;
    longint integ;
    tick_out_t expected_ticks[$];
    int mismatches;

    function new();
      kp = psc_pkg::KP_GAIN_RESET;
      ki = psc_pkg::KI_GAIN_RESET;
      hold = psc_pkg::HOLD_TICKS_RESET;
      sp_step = psc_pkg::SETPOINT_STEP_RESET;
      sp_max = psc_pkg::SETPOINT_MAX_RESET;
      period = psc_pkg::DISPLAY_PERIOD_RESET;
      up_latch = 0;
      down_latch = 0;
      mode = 0;
      below_max = 1;
      duty = 0;
      target = 0;
      up_hold = 0;
      down_hold = 0;
      both_hold = 0;
      strobe_cnt = 0;
      integ = 0;
      mismatches = 0;
    endfunction

    function void set_reg(psc_pkg::psc_reg_t idx, logic [psc_pkg::DATA_W-1:0] val);
      case (idx)
        psc_pkg::REG_KP_GAIN:        kp = val[psc_pkg::GAIN_W-1:0];
        psc_pkg::REG_KI_GAIN:        ki = val[psc_pkg::GAIN_W-1:0];
        psc_pkg::REG_HOLD_TICKS:     hold = val[psc_pkg::HOLD_W-1:0];
        psc_pkg::REG_SETPOINT_STEP:  sp_step = val[psc_pkg::STEP_W-1:0];
        psc_pkg::REG_SETPOINT_MAX:   sp_max = val[psc_pkg::SETPOINT_W-1:0];
        psc_pkg::REG_DISPLAY_PERIOD: period = val[psc_pkg::PERIOD_W-1:0];
        default: ;
      endcase
    endfunction

    // Advances the controller by one accepted tick and queues its result.
    function void predict_tick(bit up, bit dn, logic signed [psc_pkg::SPEED_W-1:0] speed);
      longint err, lim, psum, whole;
      int drv;
      bit strobe;
      tick_out_t t;
      strobe = 0;

      // Buttons act on release.
      if (up && !up_latch) up_latch = 1;
      else if (!up && up_latch) begin
        if (mode) target += sp_step;
        else duty += 1;
        up_latch = 0;
      end
      if (dn && !down_latch) down_latch = 1;
      else if (!dn && down_latch) begin
        if (mode) target -= sp_step;
        else duty -= 1;
        down_latch = 0;
      end

      // Holding both buttons toggles the mode once, when the count first hits hold.
      if (up && dn) begin
        if (both_hold < 1023) begin
          both_hold++;
          if (both_hold == hold) begin
            mode = !mode;
            duty = 0;
            target = 0;
          end
        end
      end else begin
        both_hold = 0;
      end

      // Holding either button steps the duty.
      up_hold = up ? up_hold + 1 : 0;
      down_hold = dn ? down_hold + 1 : 0;
      if (up_hold >= hold) begin
        duty += 1;
        up_hold = 0;
      end
      if (down_hold >= hold) begin
        duty -= 1;
        down_hold = 0;
      end
      up_hold &= 'h3FF;
      down_hold &= 'h3FF;

      if (duty < 0) duty = 0;
      if (duty > DUTY_FS) duty = DUTY_FS;
      if (target < 0) target = 0;
      if (target > sp_max) target = sp_max;

      // Display refresh.
      strobe_cnt = (strobe_cnt + 1) & 'h1FF;
      if (strobe_cnt >= period) begin
        strobe = 1;
        strobe_cnt = 0;
      end

      // Drive byte: scaled duty in open loop, clamped PI sum in closed loop.
      if (!mode) begin
        drv = duty * 255 / DUTY_FS;
        if (drv > 255) drv = 255;
      end else begin
        err = longint'(target) - longint'(speed);
        lim = longint'(1024) << FRAC;
        if (below_max) begin
          integ += err * ki;
          if (integ > lim) integ = lim;
          if (integ < -lim) integ = -lim;
        end
        psum = err * kp + integ;
        if (psum <= 0) begin
          drv = 0;
        end else begin
          whole = psum >>> FRAC;
          drv = (whole >= 255) ? 255 : int'(whole);
        end
        below_max = (drv < 255);
      end

      t.drive = drv[psc_pkg::DRIVE_W-1:0];
      t.mode = mode;
      t.duty = duty[psc_pkg::DUTY_W-1:0];
      t.setpoint = target[psc_pkg::SETPOINT_W-1:0];
      t.strobe = strobe;
      expected_ticks.push_back(t);
    endfunction

    function void report(string what, int want, int got);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t mismatch on %s: expected %0d, got %0d", $time, what, want, got);
    endfunction

    function void check_tick(tick_out_t got);
      tick_out_t want;
      if (expected_ticks.size() == 0) begin
        report("unexpected result, drive_level", -1, got.drive);
        return;
      end
      want = expected_ticks.pop_front();
      if (got.drive !== want.drive) report("drive_level", want.drive, got.drive);
      if (got.mode !== want.mode) report("closed_loop", want.mode, got.mode);
      if (got.duty !== want.duty) report("duty_percent", want.duty, got.duty);
      if (got.setpoint !== want.setpoint)
        report("speed_setpoint", want.setpoint, got.setpoint);
      if (got.strobe !== want.strobe) report("display_strobe", want.strobe, got.strobe);
    endfunction
  endclass

  logic                                  clk;
  logic                                  rst;
  logic                                  in_valid;
  logic                                  in_stall;
  logic                                  up_pressed;
  logic                                  down_pressed;
  logic signed [psc_pkg::SPEED_W-1:0]    measured_speed;
  logic                                  out_valid;
  logic                                  out_stall;
  logic [psc_pkg::DRIVE_W-1:0]           drive_level;
  logic                                  closed_loop;
  logic [psc_pkg::DUTY_W-1:0]            duty_percent;
  logic [psc_pkg::SETPOINT_W-1:0]        speed_setpoint;
  logic                                  display_strobe;
  logic                                  psel;
  logic                                  penable;
  logic                                  pwrite;
  logic [psc_pkg::ADDR_W-1:0]            paddr;
  logic [psc_pkg::DATA_W-1:0]            pwdata;
  logic [psc_pkg::DATA_W-1:0]            prdata;
  logic                                  pready;

  tick_scoreboard_t sb;
  int ticks_sent = 0;
  int idle_cycles = 0;
  int tx_gap_pct = 0;
  int rx_stall_pct = 0;
  bit no_idle = 0;
  bit hold_off_req = 0;

  pi_speed_controller_with_buttons #(
    .FRAC_BITS(FRAC),
    .DUTY_MAX (DUTY_FS)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .up_pressed    (up_pressed),
    .down_pressed  (down_pressed),
    .measured_speed(measured_speed),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .drive_level   (drive_level),
    .closed_loop   (closed_loop),
    .duty_percent  (duty_percent),
    .speed_setpoint(speed_setpoint),
    .display_strobe(display_strobe),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    out_stall = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_stall <= 1;
        repeat (60) @(negedge clk);
        out_stall <= 0;
        hold_off_req = 0;
      end else if (!no_idle && $urandom_range(0, 99) < rx_stall_pct) begin
        out_stall <= 1;
        repeat ($urandom_range(1, 7)) @(negedge clk);
        out_stall <= 0;
      end
    end
  end

  // Every result transfer is checked against the oldest expected tick.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_tick(tick_out_t'{drive_level, closed_loop, duty_percent,
                                speed_setpoint, display_strobe});
  end

  // Ends the run when no transfer happens for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offers one tick, with an optional gap first, and waits for its transfer.
  task automatic send_tick(bit up, bit dn, logic signed [psc_pkg::SPEED_W-1:0] spd);
    int gap;
    if (!no_idle && $urandom_range(0, 99) < tx_gap_pct) begin
      gap = $urandom_range(1, 7);
      @(negedge clk);
      in_valid <= 0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1;
    up_pressed <= up;
    down_pressed <= dn;
    measured_speed <= spd;
    do @(posedge clk); while (in_stall);
    sb.predict_tick(up, dn, spd);
    ticks_sent++;
  endtask

  // Mostly a speed near the setpoint, sometimes anything the field can hold.
  function automatic logic signed [psc_pkg::SPEED_W-1:0] pick_speed();
    int s;
    if ($urandom_range(0, 7) == 0) begin
      s = $urandom_range(0, 8191);
      return s[psc_pkg::SPEED_W-1:0];
    end
    s = int'($urandom_range(0, 600)) - 300 + sb.target;
    if (s < -512) s = -512;
    if (s > 4095) s = 4095;
    return s[psc_pkg::SPEED_W-1:0];
  endfunction

  // Stops offering ticks and waits until every result has come back.
  task automatic drain();
    @(negedge clk);
    in_valid <= 0;
    while (sb.expected_ticks.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic write_reg(psc_pkg::psc_reg_t idx, logic [psc_pkg::DATA_W-1:0] val);
    @(negedge clk);
    psel <= 1;
    pwrite <= 1;
    penable <= 0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, val);
    @(negedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
  endtask

  task automatic apply_settings(logic [psc_pkg::DATA_W-1:0] kp,
                                logic [psc_pkg::DATA_W-1:0] ki,
                                logic [psc_pkg::DATA_W-1:0] hold,
                                logic [psc_pkg::DATA_W-1:0] sp_step,
                                logic [psc_pkg::DATA_W-1:0] sp_max,
                                logic [psc_pkg::DATA_W-1:0] period);
    drain();
    write_reg(psc_pkg::REG_KP_GAIN, kp);
    write_reg(psc_pkg::REG_KI_GAIN, ki);
    write_reg(psc_pkg::REG_HOLD_TICKS, hold);
    write_reg(psc_pkg::REG_SETPOINT_STEP, sp_step);
    write_reg(psc_pkg::REG_SETPOINT_MAX, sp_max);
    write_reg(psc_pkg::REG_DISPLAY_PERIOD, period);
    tx_gap_pct = 15 * $urandom_range(0, 2);
    rx_stall_pct = 15 * $urandom_range(0, 2);
  endtask

  // Random button gestures: taps, single holds, both-button holds and noise.
  task automatic button_phase(int n_ticks);
    int start, kind, len, cap;
    start = ticks_sent;
    while (ticks_sent - start < n_ticks) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2, 3: begin
          len = $urandom_range(1, 3);
          repeat (len) send_tick(kind < 2, kind >= 2, pick_speed());
          send_tick(0, 0, pick_speed());
        end
        4, 5: begin
          cap = (sb.hold <= 3) ? 120 : ((sb.hold < 40) ? sb.hold : 40) + 3;
          len = $urandom_range(1, cap);
          repeat (len) send_tick(kind == 4, kind == 5, pick_speed());
          send_tick(0, 0, pick_speed());
        end
        6: begin
          // With a hold from 1 to 250, long enough to reach the hold count and toggle the mode.
          if (sb.hold <= 250) len = sb.hold + $urandom_range(0, 3);
          else len = $urandom_range(1, 4);
          if (len < 1) len = 1;
          repeat (len) send_tick(1, 1, pick_speed());
          send_tick(0, 0, pick_speed());
        end
        7: repeat ($urandom_range(1, 8)) send_tick(0, 0, pick_speed());
        8: repeat ($urandom_range(1, 8))
          send_tick($urandom_range(0, 1), $urandom_range(0, 1), pick_speed());
        default: repeat ($urandom_range(1, 4)) send_tick(1, 1, pick_speed());
      endcase
    end
  endtask

  initial begin
    sb = new();
    rst = 1;
    in_valid = 0;
    up_pressed = 0;
    down_pressed = 0;
    measured_speed = '0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = '0;
    pwdata = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed: speed extremes and taps in open loop at the reset settings.
    send_tick(0, 0, 13'sd0);
    send_tick(0, 0, 13'sd4095);
    send_tick(0, 0, -13'sd4096);
    send_tick(1, 0, -13'sd512);
    send_tick(0, 0, 13'sd0);
    send_tick(0, 1, 13'sd0);
    send_tick(0, 0, 13'sd0);
    send_tick(0, 1, 13'sd0);
    send_tick(0, 0, 13'sd0);

    // Directed with a short hold: auto-step, mode toggle, closed-loop extremes.
    drain();
    write_reg(psc_pkg::REG_HOLD_TICKS, 2);
    repeat (3) send_tick(1, 0, 13'sd100);
    send_tick(0, 0, 13'sd100);
    repeat (3) send_tick(1, 1, 13'sd0);
    send_tick(0, 0, 13'sd0);
    send_tick(1, 0, 13'sd0);
    send_tick(0, 0, 13'sd4095);
    send_tick(0, 0, -13'sd512);
    send_tick(0, 0, 13'sd50);
    send_tick(0, 1, -13'sd4096);
    send_tick(0, 0, 13'sd50);
    send_tick(0, 1, 13'sd0);
    send_tick(0, 0, 13'sd0);

    tx_gap_pct = 15;
    rx_stall_pct = 15;
    button_phase(100);

    // Largest gains and steps; the receiver holds off long enough to back up the input.
    apply_settings(24'hFFFFFF, 24'hFFFFFF, 3, 255, 4095, 1);
    hold_off_req = 1;
    button_phase(120);

    // Zero gains, zero hold, zero step, zero setpoint limit and a zero period.
    apply_settings(0, 0, 0, 0, 0, 0);
    button_phase(80);

    // Hold of one tick and the longest display period.
    apply_settings($urandom_range(0, 24'h7FFFFF), $urandom_range(0, 200000), 1, 1,
                   $urandom_range(0, 4095), 255);
    button_phase(100);

    // Longest hold: both buttons held past the saturation of their counter.
    // The lowered period fires at once on a count left from the previous phase.
    apply_settings(psc_pkg::KP_GAIN_RESET, psc_pkg::KI_GAIN_RESET, 1023,
                   $urandom_range(1, 255), psc_pkg::SETPOINT_MAX_RESET, 3);
    repeat (1030) send_tick(1, 1, pick_speed());
    button_phase(40);

    apply_settings(psc_pkg::KP_GAIN_RESET, psc_pkg::KI_GAIN_RESET,
                   psc_pkg::HOLD_TICKS_RESET, psc_pkg::SETPOINT_STEP_RESET,
                   psc_pkg::SETPOINT_MAX_RESET, psc_pkg::DISPLAY_PERIOD_RESET);
    button_phase(100);

    // Random settings; the last one runs with no idling on either side.
    for (int p = 0; p < 3; p++) begin
      apply_settings($urandom_range(0, 24'h7FFFFF), $urandom_range(0, 24'h3FFFF),
                     $urandom_range(2, 12), $urandom_range(1, 255),
                     $urandom_range(0, 4095), $urandom_range(1, 20));
      if (p == 2) no_idle = 1;
      button_phase(50);
    end

    drain();
    if (sb.mismatches == 0 && sb.expected_ticks.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/psc_pkg.sv
rtl/core/psc_buttons.sv
rtl/core/psc_pi.sv
rtl/core/pi_speed_controller_with_buttons.sv
verif/testbench.sv
